@@ src/per_sensor_moving_average_alarm_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the per-sensor moving average alarm checker
// Each macro expects clk and arst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef PER_SENSOR_MOVING_AVERAGE_ALARM_ASSERT_SVH
`define PER_SENSOR_MOVING_AVERAGE_ALARM_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define PSMAA_AST_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define PSMAA_AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/psmaa_pkg.sv @@
// ----------------------------------------------------------------------------
// psmaa_pkg
// Shared types and constants of the per-sensor moving average alarm.
// ----------------------------------------------------------------------------
`default_nettype none

package psmaa_pkg;

	localparam int ID_W  = 16;
	localparam int SMP_W = 16;

	// item kinds on the input tuser bit
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	// register index (paddr[2])
	localparam logic REG_MIN_TEMP = 1'b0;
	localparam logic REG_MAX_TEMP = 1'b1;

	localparam logic signed [7:0] MIN_TEMP_RST = 8'sd15;
	localparam logic signed [7:0] MAX_TEMP_RST = 8'sd25;

	typedef enum logic [1:0] {
		ST_NORMAL  = 2'd0,
		ST_HOT     = 2'd1,
		ST_COLD    = 2'd2,
		ST_UNKNOWN = 2'd3
	} status_t;

	// broadcast to every cell of the table
	typedef struct packed {
		logic                    load;   // shift the chain, new entry at cell 0
		logic                    read;   // reading for a nonzero id
		logic [ID_W-1:0]         id;
		logic signed [SMP_W-1:0] sample;
	} cell_ctrl_t;

endpackage

`default_nettype wire

@@ src/psmaa_cell.sv @@
// ----------------------------------------------------------------------------
// psmaa_cell
// One table entry: sensor id, sample window and running window sum. Loads
// shift the whole chain by one cell; a matching reading updates this cell.
// ----------------------------------------------------------------------------
`default_nettype none

module psmaa_cell #(
	parameter int AVG_LEN = 5,
	parameter int SUM_W   = 19
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  psmaa_pkg::cell_ctrl_t            ctrl,
	input  logic                             prev_vld,
	input  logic                             prev_shd,
	input  logic [psmaa_pkg::ID_W-1:0]       prev_id,
	input  logic [AVG_LEN-1:0][psmaa_pkg::SMP_W-1:0] prev_win,
	input  logic [SUM_W-1:0]                 prev_sum,
	output logic                             fwd_vld,
	output logic                             fwd_shd,
	output logic [psmaa_pkg::ID_W-1:0]       fwd_id,
	output logic [AVG_LEN-1:0][psmaa_pkg::SMP_W-1:0] fwd_win,
	output logic [SUM_W-1:0]                 fwd_sum,
	output logic                             hit
);
	import psmaa_pkg::*;

	logic                         vld_q;
	logic                         shd_q;
	logic                         hit_q;
	logic [ID_W-1:0]              id_q;
	logic [AVG_LEN-1:0][SMP_W-1:0] win_q;
	logic signed [SUM_W-1:0]      sum_q;
	logic                         hit_now;
	logic signed [SUM_W-1:0]      sum_nxt;

	// shadowed entries are older copies of an id that was loaded again
	assign hit_now = vld_q && !shd_q && (id_q == ctrl.id);
	assign sum_nxt = sum_q + SUM_W'($signed(ctrl.sample))
		- SUM_W'($signed(win_q[AVG_LEN-1]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			shd_q <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			hit_q <= ctrl.read && hit_now;
			if (ctrl.load) begin
				vld_q <= prev_vld;
				shd_q <= prev_shd;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			id_q  <= prev_id;
			win_q <= prev_win;
			sum_q <= prev_sum;
		end else if (ctrl.read && hit_now) begin
			for (int k = AVG_LEN - 1; k > 0; k--) begin
				win_q[k] <= win_q[k-1];
			end
			win_q[0] <= ctrl.sample;
			sum_q    <= sum_nxt;
		end
	end

	assign fwd_vld = vld_q;
	assign fwd_shd = shd_q || (vld_q && (id_q == ctrl.id));
	assign fwd_id  = id_q;
	assign fwd_win = win_q;
	assign fwd_sum = sum_q;
	assign hit     = hit_q;

endmodule

`default_nettype wire

@@ src/per_sensor_moving_average_alarm.sv @@
// ----------------------------------------------------------------------------
// per_sensor_moving_average_alarm
// Sensor table as a row of cells with per-sensor sample windows; readings
// give the floored window average and a hot / cold / normal / unknown status.
// ----------------------------------------------------------------------------
//  channel  dir  word                                   accepted when
//  s_*      in   tdata: probe_id, sample; tuser: func    s_tvalid & s_tready
//  m_*      out  tdata: sensor_tag, average; tuser: st   m_tvalid & m_tready
//  apb      in   min_temp @0x0, max_temp @0x4            psel & penable & pwrite
//
//  Loads and end markers leave no result and do not hold off the next item.
//  A reading passes the cell update, then the table readout and limit
//  compare; the next item may enter as the reciprocal multiply loads the
//  output register, which holds the result word.
//  Reset empties the table at once (valid bits in the cells).
//  A held output word stalls the multiply stage and with it s_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module per_sensor_moving_average_alarm #(
	parameter int MAX_SENSORS = 16,
	parameter int AVG_LEN     = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	// apb
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] probe_id, [31:16] sample
	input  logic [0:0]  s_tuser,   // [0] func
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [15:0] sensor_tag, [31:16] average
	output logic [1:0]  m_tuser    // [1:0] status
);
	import psmaa_pkg::*;

	localparam int SUM_W  = SMP_W + $clog2(AVG_LEN);
	localparam int LIM_W  = SUM_W + 1;
	localparam int CNT_W  = $clog2(MAX_SENSORS + 1);
	localparam int RL     = $clog2(AVG_LEN);
	localparam int SH     = SUM_W + RL;
	localparam int MUL_W  = SUM_W + 1;
	localparam int PROD_W = SUM_W + MUL_W;
	localparam longint unsigned RECIP_L = ((64'd1 << SH) / AVG_LEN) + 64'd1;
	localparam logic [MUL_W-1:0] RECIP   = MUL_W'(RECIP_L);
	localparam logic [SUM_W-1:0] SUM_OFS = SUM_W'(AVG_LEN * 32768);

	logic signed [7:0] min_temp_q;
	logic signed [7:0] max_temp_q;
	logic              cfg_wr;

	logic [CNT_W-1:0]  count_q;
	logic              full;
	logic              acc;
	logic              func;
	logic [ID_W-1:0]   in_id;
	logic [SMP_W-1:0]  in_sample;
	cell_ctrl_t        ctrl;

	logic signed [8:0]  lim_sum;
	logic [SMP_W-1:0]   mid;
	logic [SUM_W-1:0]   mid_sum;

	logic [MAX_SENSORS-1:0]                        fwd_vld;
	logic [MAX_SENSORS-1:0]                        fwd_shd;
	logic [MAX_SENSORS-1:0][ID_W-1:0]              fwd_id;
	logic [MAX_SENSORS-1:0][AVG_LEN-1:0][SMP_W-1:0] fwd_win;
	logic [MAX_SENSORS-1:0][SUM_W-1:0]             fwd_sum;
	logic [MAX_SENSORS-1:0]                        hits;

	// stage 1: table readout and limit compare
	logic              s1_v_q;
	logic [ID_W-1:0]   tag_s1;
	logic [SUM_W-1:0]  sel_sum;
	logic signed [LIM_W-1:0] sum_x;
	logic signed [LIM_W-1:0] hi_lim;
	logic signed [LIM_W-1:0] lo_lim;
	status_t           st_s1;

	// stage 2: reciprocal multiply into the output register
	logic              s2_v_q;
	logic [ID_W-1:0]   tag_s2;
	logic [SUM_W-1:0]  sum_s2;
	status_t           st_s2;
	logic              s2_adv;
	logic [SUM_W-1:0]  ofs_sum;
	logic [PROD_W-1:0] prod;
	logic [SMP_W-1:0]  quo;

	logic              out_v_q;
	logic [ID_W-1:0]   tag_q;
	status_t           st_q;
	logic [SMP_W-1:0]  avg_q;

	// ---------------- configuration ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_temp_q <= MIN_TEMP_RST;
			max_temp_q <= MAX_TEMP_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_MIN_TEMP: min_temp_q <= pwdata[7:0];
				REG_MAX_TEMP: max_temp_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MIN_TEMP: prdata = {24'd0, min_temp_q};
			REG_MAX_TEMP: prdata = {24'd0, max_temp_q};
			default:      prdata = 32'd0;
		endcase
	end

	// ---------------- input side ----------------
	assign func      = s_tuser[0];
	assign in_id     = s_tdata[15:0];
	assign in_sample = s_tdata[31:16];
	assign acc       = s_tvalid && s_tready;
	assign full      = (count_q == CNT_W'(MAX_SENSORS));

	assign ctrl.load   = acc && (func == FUNC_LOAD) && !full;
	assign ctrl.read   = acc && (func == FUNC_READ) && (in_id != '0);
	assign ctrl.id     = in_id;
	assign ctrl.sample = in_sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.load) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// midpoint of the limits in Q8.8: (min + max) * 128
	assign lim_sum = 9'(min_temp_q) + 9'(max_temp_q);
	assign mid     = {lim_sum[8:0], 7'd0};
	assign mid_sum = SUM_W'($signed(mid)) * SUM_W'(AVG_LEN);

	// ---------------- cell chain ----------------
	for (genvar i = 0; i < MAX_SENSORS; i++) begin : g_cell
		if (i == 0) begin : g_head
			psmaa_cell #(
				.AVG_LEN (AVG_LEN),
				.SUM_W   (SUM_W)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.prev_vld (1'b1),
				.prev_shd (1'b0),
				.prev_id  (in_id),
				.prev_win ({AVG_LEN{mid}}),
				.prev_sum (mid_sum),
				.fwd_vld  (fwd_vld[i]),
				.fwd_shd  (fwd_shd[i]),
				.fwd_id   (fwd_id[i]),
				.fwd_win  (fwd_win[i]),
				.fwd_sum  (fwd_sum[i]),
				.hit      (hits[i])
			);
		end else begin : g_body
			psmaa_cell #(
				.AVG_LEN (AVG_LEN),
				.SUM_W   (SUM_W)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.prev_vld (fwd_vld[i-1]),
				.prev_shd (fwd_shd[i-1]),
				.prev_id  (fwd_id[i-1]),
				.prev_win (fwd_win[i-1]),
				.prev_sum (fwd_sum[i-1]),
				.fwd_vld  (fwd_vld[i]),
				.fwd_shd  (fwd_shd[i]),
				.fwd_id   (fwd_id[i]),
				.fwd_win  (fwd_win[i]),
				.fwd_sum  (fwd_sum[i]),
				.hit      (hits[i])
			);
		end
	end

	// ---------------- stage 1 ----------------
	// at most one cell hits, so the readout is a plain OR
	always_comb begin
		sel_sum = '0;
		for (int i = 0; i < MAX_SENSORS; i++) begin
			sel_sum = sel_sum | (hits[i] ? fwd_sum[i] : '0);
		end
	end

	assign sum_x  = LIM_W'($signed(sel_sum));
	assign hi_lim = (LIM_W'(max_temp_q) * LIM_W'(AVG_LEN)) <<< 8;
	assign lo_lim = (LIM_W'(min_temp_q) * LIM_W'(AVG_LEN)) <<< 8;

	always_comb begin
		if (hits == '0) begin
			st_s1 = ST_UNKNOWN;
		end else if (sum_x > hi_lim) begin
			st_s1 = ST_HOT;
		end else if (sum_x < lo_lim) begin
			st_s1 = ST_COLD;
		end else begin
			st_s1 = ST_NORMAL;
		end
	end

	assign s2_adv   = s2_v_q && (!out_v_q || m_tready);
	assign s_tready = !s1_v_q && (!s2_v_q || s2_adv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			s2_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			s1_v_q <= ctrl.read;
			// s2 is always free when s1 holds a word
			s2_v_q <= s1_v_q || (s2_v_q && !s2_adv);
			if (s2_adv) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.read) begin
			tag_s1 <= in_id;
		end
		if (s1_v_q) begin
			tag_s2 <= tag_s1;
			sum_s2 <= sel_sum;
			st_s2  <= st_s1;
		end
	end

	// ---------------- stage 2 ----------------
	// floor(sum / AVG_LEN): offset to unsigned, multiply by the reciprocal,
	// then remove the offset by flipping the quotient's top bit
	assign ofs_sum = sum_s2 + SUM_OFS;
	assign prod    = PROD_W'(ofs_sum) * PROD_W'(RECIP);
	assign quo     = prod[SH +: SMP_W];

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			tag_q <= tag_s2;
			st_q  <= st_s2;
			avg_q <= (st_s2 == ST_UNKNOWN) ? '0 : {~quo[SMP_W-1], quo[SMP_W-2:0]};
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {avg_q, tag_q};
	assign m_tuser  = st_q;

endmodule

`default_nettype wire

@@ src/psmaa_chk.sv @@
// ----------------------------------------------------------------------------
// psmaa_chk
// Port-level checker for the per-sensor moving average alarm, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "per_sensor_moving_average_alarm_assert.svh"

module psmaa_chk (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire [31:0] s_tdata,
	input wire [0:0]  s_tuser,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [31:0] m_tdata,
	input wire [1:0]  m_tuser
);
	import psmaa_pkg::*;

	// a reading holds off the next input word in the cycle after it is taken
	`PSMAA_AST_NEXT(a_read_gap, s_tvalid && s_tready && (s_tuser[0] == FUNC_READ) && (s_tdata[15:0] != 16'd0), !s_tready, "input word taken right after a reading")

	// a reading for a nonzero id has a result word up later
	`PSMAA_AST_NOW(a_read_word, s_tvalid && s_tready && (s_tuser[0] == FUNC_READ) && (s_tdata[15:0] != 16'd0), ##3 m_tvalid, "no result word for a reading")

	// unknown ids report a zero average
	`PSMAA_AST_NOW(a_unknown_zero, m_tvalid && (m_tuser == ST_UNKNOWN), m_tdata[31:16] == 16'd0, "nonzero average for unknown id")

	// a stalled result word holds
	`PSMAA_AST_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed under stall")

endmodule

bind per_sensor_moving_average_alarm psmaa_chk u_psmaa_chk (.*);

`default_nettype wire

@@ tb/sv/per_sensor_moving_average_alarm_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// per_sensor_moving_average_alarm_checker
// Watches the register port and both streams, keeps its own copy of the
// sensor table and windows, predicts each result word and compares it.
// ----------------------------------------------------------------------------
module per_sensor_moving_average_alarm_checker
	import psmaa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] probe_id, [31:16] sample
	input  logic [0:0]  s_tuser,   // [0] func
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [15:0] sensor_tag, [31:16] average
	input  logic [1:0]  m_tuser,   // [1:0] status
	output int          n_fail,
	output int          n_pending
);

	localparam int MAX_SENSORS = 16;
	localparam int AVG_LEN     = 5;

	typedef struct {
		logic [15:0]        tag;
		status_t            st;
		logic signed [15:0] avg;
	} alarm_t;

	logic signed [7:0]  lim_lo = MIN_TEMP_RST;
	logic signed [7:0]  lim_hi = MAX_TEMP_RST;
	logic [15:0]        table_id [MAX_SENSORS];
	logic signed [15:0] window [MAX_SENSORS][AVG_LEN];
	int                 n_loaded = 0;
	alarm_t             alarm_q [$];

	initial begin
		n_fail = 0;
		n_pending = 0;
	end

	task automatic report(input string msg);
		n_fail++;
		if (n_fail <= 10)
			$display("%t %s", $realtime, msg);
	endtask

	// applies one input word to the table and queues the alarm word it causes
	function automatic void track_sensor_word(input logic func, input logic [15:0] id,
			input logic signed [15:0] smp);
		int slot;
		int sum;
		int q;
		int k;
		logic signed [15:0] mid;
		alarm_t res;
		if (func == FUNC_LOAD) begin
			if (n_loaded < MAX_SENSORS) begin
				mid = 16'((int'(lim_lo) + int'(lim_hi)) * 128);
				table_id[n_loaded] = id;
				for (k = 0; k < AVG_LEN; k++)
					window[n_loaded][k] = mid;
				n_loaded++;
			end
			return;
		end
		if (id == '0)
			return;   // end marker
		// newest entry wins on duplicate ids
		slot = -1;
		for (k = n_loaded - 1; k >= 0 && slot < 0; k--)
			if (table_id[k] == id)
				slot = k;
		res.tag = id;
		if (slot < 0) begin
			res.st = ST_UNKNOWN;
			res.avg = '0;
		end else begin
			for (k = AVG_LEN - 1; k > 0; k--)
				window[slot][k] = window[slot][k-1];
			window[slot][0] = smp;
			sum = 0;
			for (k = 0; k < AVG_LEN; k++)
				sum += window[slot][k];
			q = sum / AVG_LEN;
			if (sum % AVG_LEN != 0 && sum < 0)
				q--;
			// limits compare against the exact mean, hot first
			if (sum > int'(lim_hi) * 256 * AVG_LEN)
				res.st = ST_HOT;
			else if (sum < int'(lim_lo) * 256 * AVG_LEN)
				res.st = ST_COLD;
			else
				res.st = ST_NORMAL;
			res.avg = 16'(q);
		end
		alarm_q.push_back(res);
	endfunction

	always @(posedge clk) begin
		alarm_t want;
		logic [7:0] reg_val;
		if (arst_n) begin
			if (psel && penable && pready) begin
				reg_val = (paddr[2] == REG_MAX_TEMP) ? lim_hi : lim_lo;
				if (pwrite) begin
					if (paddr[2] == REG_MAX_TEMP)
						lim_hi = pwdata[7:0];
					else
						lim_lo = pwdata[7:0];
				end else if (prdata[7:0] !== reg_val) begin
					report($sformatf("register read at %h: expected %h, got %h",
						paddr, reg_val, prdata[7:0]));
				end
			end
			if (m_tvalid && m_tready) begin
				if (alarm_q.size() == 0) begin
					report($sformatf("unexpected result word: tag %h status %0d avg %0d",
						m_tdata[15:0], m_tuser, $signed(m_tdata[31:16])));
				end else begin
					want = alarm_q.pop_front();
					if (m_tdata[15:0] !== want.tag || m_tuser !== want.st ||
							m_tdata[31:16] !== want.avg) begin
						report($sformatf({"result mismatch: expected tag %h status %0d ",
							"avg %0d, got tag %h status %0d avg %0d"},
							want.tag, want.st, want.avg,
							m_tdata[15:0], m_tuser, $signed(m_tdata[31:16])));
					end
				end
			end
			if (s_tvalid && s_tready)
				track_sensor_word(s_tuser[0], s_tdata[15:0], s_tdata[31:16]);
			n_pending = alarm_q.size();
		end
	end

endmodule

@@ tb/sv/per_sensor_moving_average_alarm_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// per_sensor_moving_average_alarm_test
// Drives loads and readings in bursts through several limit settings while
// the result side stalls; the checker predicts and compares every word.
// ----------------------------------------------------------------------------
module per_sensor_moving_average_alarm_test;
	import psmaa_pkg::*;

	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_WORDS    = 110;

	typedef enum logic [1:0] {
		RDY_ALWAYS,
		RDY_RANDOM,
		RDY_SPARSE,
		RDY_PERIODIC
	} rdy_mode_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;   // [15:0] probe_id, [31:16] sample
	logic [0:0]  s_tuser  = '0;   // [0] func
	logic        m_tvalid;
	logic        m_tready = 1'b1;
	logic [31:0] m_tdata;         // [15:0] sensor_tag, [31:16] average
	logic [1:0]  m_tuser;         // [1:0] status
	int          n_fail;
	int          n_pending;

	int          cur_lo = 15;
	int          cur_hi = 25;
	int          burst_left = 0;
	int          quiet_cycles = 0;
	rdy_mode_t   rdy_mode = RDY_ALWAYS;
	int          rdy_left = 0;
	logic [15:0] known_ids [$];

	always #6 clk = ~clk;

	per_sensor_moving_average_alarm u_top (
		.clk, .arst_n,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser
	);

	per_sensor_moving_average_alarm_checker u_chk (
		.clk, .arst_n,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser,
		.n_fail, .n_pending
	);

	// result side: the stall pattern is picked anew whenever its random run length runs out
	always @(posedge clk) begin
		if (rdy_left == 0) begin
			rdy_mode <= rdy_mode_t'($urandom_range(0, 3));
			rdy_left <= $urandom_range(20, 80);
		end else begin
			rdy_left <= rdy_left - 1;
		end
		case (rdy_mode)
			RDY_ALWAYS: m_tready <= 1'b1;
			RDY_RANDOM: m_tready <= ($urandom_range(0, 1) == 1);
			RDY_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
			default: m_tready <= (rdy_left % 4 != 0);
		endcase
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send_word(input logic func, input logic [15:0] id, input logic [15:0] smp);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {smp, id};
		s_tuser <= func;
		do @(posedge clk); while (!s_tready);
		if (func == FUNC_LOAD)
			known_ids.push_back(id);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (n_pending != 0) @(posedge clk);
		// loads and end markers leave no result to wait for
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic idx, input logic [7:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= {24'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_limits(input int lo, input int hi);
		wait_idle();
		apb_access(1'b1, REG_MAX_TEMP, 8'(hi));
		apb_access(1'b1, REG_MIN_TEMP, 8'(lo));
		apb_access(1'b0, REG_MIN_TEMP, 8'h00);
		apb_access(1'b0, REG_MAX_TEMP, 8'h00);
		cur_lo = lo;
		cur_hi = hi;
	endtask

	// samples lean toward the limits so equality with a threshold shows up
	function automatic logic [15:0] pick_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return 16'($urandom);
		if (r < 7)
			return 16'(cur_hi * 256 + int'($urandom_range(0, 4)) - 2);
		if (r < 9)
			return 16'(cur_lo * 256 + int'($urandom_range(0, 4)) - 2);
		return ($urandom_range(0, 1) == 1) ? 16'h7FFF : 16'h8000;
	endfunction

	function automatic logic [15:0] pick_known();
		return known_ids[$urandom_range(0, known_ids.size() - 1)];
	endfunction

	task automatic send_random(input int count);
		int r;
		logic [15:0] id;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				id = ($urandom_range(0, 3) == 0) ? pick_known() : 16'($urandom);
				send_word(FUNC_LOAD, id, 16'($urandom));
			end else if (r < 14) begin
				send_word(FUNC_READ, 16'h0000, 16'($urandom));
			end else if (r < 28) begin
				send_word(FUNC_READ, 16'($urandom), pick_sample());
			end else begin
				send_word(FUNC_READ, pick_known(), pick_sample());
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limits: windows start at 20 degrees
		send_word(FUNC_LOAD, 16'h0001, 16'h7FFF);
		send_word(FUNC_LOAD, 16'hFFFF, 16'h8000);
		send_word(FUNC_LOAD, 16'h0000, 16'h0000);
		send_word(FUNC_LOAD, 16'h0001, 16'h0000);   // duplicate id
		send_word(FUNC_READ, 16'h0001, 16'h1400);
		send_word(FUNC_READ, 16'hFFFF, 16'h7FFF);
		send_word(FUNC_READ, 16'h0000, 16'h1234);   // end marker
		send_word(FUNC_READ, 16'h5A5A, 16'h0100);   // unknown id
		repeat (4) send_word(FUNC_READ, 16'hFFFF, 16'h8000);

		// widest limits: full-scale windows right at the edges
		set_limits(-128, 127);
		send_word(FUNC_LOAD, 16'h8000, 16'h0000);
		send_word(FUNC_LOAD, 16'h7FFF, 16'h0000);
		repeat (5) send_word(FUNC_READ, 16'h8000, 16'h7FFF);
		repeat (5) send_word(FUNC_READ, 16'h7FFF, 16'h8000);

		// crossed limits
		set_limits(127, -128);
		send_word(FUNC_READ, 16'h0001, 16'h0000);

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				1: set_limits(0, 0);
				2: set_limits(-128, -128);
				3: set_limits(127, 127);
				default: set_limits(int'($urandom_range(0, 255)) - 128,
					int'($urandom_range(0, 255)) - 128);
			endcase
			send_random(PHASE_WORDS);
		end

		wait_idle();
		if (n_fail == 0 && n_pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
